// File: sv/transaction_affinity_dispatcher_macros.svh
// transaction_affinity_dispatcher_macros.svh
// assertion macros shared by the dispatcher rtl; needs a clk and rst in scope
`ifndef TRANSACTION_AFFINITY_DISPATCHER_MACROS_SVH
`define TRANSACTION_AFFINITY_DISPATCHER_MACROS_SVH

// property that must hold at every edge out of reset
`define TAD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define TAD_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) else $error(msg);

`endif

// File: sv/tad_pkg.sv
// tad_pkg.sv
// shared types, codes and defaults of the transaction affinity dispatcher
// no dependencies
package tad_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int WORKERS_DEF     = 16;

  localparam int TAG_W    = 16;
  localparam int TRANS_W  = 63;
  localparam int WORKER_W = 4;
  localparam int ACTIVE_W = 5;
  localparam int COUNT_W  = 7;

  // input kind codes
  localparam logic KIND_ENQ  = 1'b0;
  localparam logic KIND_TAKE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NONE    = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_BAD_WKR = 2'd3;

  // one queue entry
  typedef struct packed {
    logic               more;
    logic               reply;
    logic [TRANS_W-1:0] trans;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  // per cycle control of the cell row
  typedef struct packed {
    logic load_enq;
    logic shift;
    logic keep_head;
  } cell_ctl_t;

  // claim table command
  typedef struct packed {
    logic clear;
    logic set;
  } claim_cmd_t;

endpackage

// File: sv/tad_cell.sv
// tad_cell.sv
// one position of the queue row; on a shift takes its upper neighbor's entry, or at the tail a kept head entry
// depends on tad_pkg
module tad_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7,
  parameter int IDX_W = 6
) (
  input  logic                clk,
  input  tad_pkg::cell_ctl_t  ctl,
  input  logic [CNT_W-1:0]    fill,
  input  logic [IDX_W-1:0]    tail,
  input  tad_pkg::entry_t     enq_entry,
  input  tad_pkg::entry_t     head_entry,
  input  tad_pkg::entry_t     upper_entry,
  output tad_pkg::entry_t     entry
);

  tad_pkg::entry_t entry_next;

  // enqueue lands at the fill position; rotation moves entries toward the head
  always_comb begin
    entry_next = entry;
    if (ctl.load_enq && fill == CNT_W'(IDX)) begin
      entry_next = enq_entry;
    end else if (ctl.shift) begin
      if (ctl.keep_head && tail == IDX_W'(IDX)) begin
        entry_next = head_entry;
      end else begin
        entry_next = upper_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// File: sv/tad_claims.sv
// tad_claims.sv
// per worker claim table with a parallel lookup of one transaction id
// depends on tad_pkg
module tad_claims #(
  parameter int WORKERS = tad_pkg::WORKERS_DEF,
  parameter int WID_W   = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tad_pkg::claim_cmd_t          cmd,
  input  logic [WID_W-1:0]             self_id,
  input  logic [tad_pkg::TRANS_W-1:0]  set_trans,
  input  logic [tad_pkg::COUNT_W-1:0]  count,
  input  logic [tad_pkg::TRANS_W-1:0]  query_trans,
  output logic                         hit_other
);

  logic [WORKERS-1:0]                valid;
  logic [tad_pkg::TRANS_W-1:0]       trans [WORKERS];
  logic [WORKERS-1:0]                match;

  // claims held by other workers inside the active range
  always_comb begin
    for (int i = 0; i < WORKERS; i++) begin
      match[i] = valid[i] && (WID_W'(i) != self_id) &&
                 (tad_pkg::COUNT_W'(i) < count) && (trans[i] == query_trans);
    end
  end
  assign hit_other = |match;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.set) begin
      valid[self_id] <= 1'b1;
    end else if (cmd.clear) begin
      valid[self_id] <= 1'b0;
    end
  end

  // claimed ids
  always_ff @(posedge clk) begin
    if (cmd.set) begin
      trans[self_id] <= set_trans;
    end
  end

endmodule

// File: sv/transaction_affinity_dispatcher.sv
// Channel  Dir  Fields (low bit first)
// s_*      in   tuser: kind; tdata: worker, request_tag, trans_id, is_reply, more_follow
// m_*      out  tuser: status; tdata: granted_tag, granted_trans, granted_reply
// cfg_*    in   data: active_workers
// an enqueue, a rejected take or a take on an empty queue goes straight to the done state;
// a take scans by rotating the whole queue through the head cell once
// reset clears the fill count, the claims and sets active_workers to 1
// one word is in work at a time; a stalled result holds the block in its done state
`include "transaction_affinity_dispatcher_macros.svh"
module transaction_affinity_dispatcher #(
  parameter int QUEUE_DEPTH = tad_pkg::QUEUE_DEPTH_DEF,
  parameter int WORKERS     = tad_pkg::WORKERS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,  // worker, request_tag, trans_id, is_reply, more_follow
  input  logic        s_tuser,  // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,  // granted_tag, granted_trans, granted_reply
  output logic [1:0]  m_tuser,  // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data  // active_workers
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int WID_W = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int CW    = tad_pkg::COUNT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                   state, state_next;
  logic [CNT_W-1:0]             fill, fill_next;
  logic [CNT_W-1:0]             cnt, cnt_next;
  logic [CNT_W-1:0]             steps, steps_next;
  logic                         granted, granted_next;
  logic [WID_W-1:0]             take_w, take_w_next;
  logic [tad_pkg::ACTIVE_W-1:0] active;
  logic [1:0]                   res_status, res_status_next;
  tad_pkg::entry_t              res_entry, res_entry_next;

  tad_pkg::entry_t              enq_entry;
  tad_pkg::entry_t              cells [QUEUE_DEPTH];
  tad_pkg::entry_t              head;
  tad_pkg::cell_ctl_t           ctl;
  tad_pkg::claim_cmd_t          ccmd;
  logic [CW-1:0]                eff;
  logic [tad_pkg::WORKER_W-1:0] in_worker;
  logic                         accept, bad_w, hit, grant_now, out_free;
  logic [IDX_W-1:0]             tail;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // unpack the input word
  assign in_worker       = s_tdata[3:0];
  assign enq_entry.tag   = s_tdata[19:4];
  assign enq_entry.trans = s_tdata[82:20];
  assign enq_entry.reply = s_tdata[83];
  assign enq_entry.more  = s_tdata[84];

  // effective worker count
  assign eff   = (CW'(active) > CW'(WORKERS)) ? CW'(WORKERS) : CW'(active);
  assign bad_w = CW'(in_worker) >= eff;

  assign head      = cells[0];
  assign grant_now = (state == S_SCAN) && !granted && (!head.reply || !hit);
  assign tail      = IDX_W'(cnt - CNT_W'(1));

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= tad_pkg::ACTIVE_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      active <= cfg_data;
    end
  end

  // sequencer
  always_comb begin
    state_next      = state;
    fill_next       = fill;
    cnt_next        = cnt;
    steps_next      = steps;
    granted_next    = granted;
    take_w_next     = take_w;
    res_status_next = res_status;
    res_entry_next  = res_entry;
    ctl             = '0;
    ccmd            = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_entry_next = '0;
          take_w_next    = WID_W'(in_worker);
          state_next     = S_DONE;
          if (s_tuser == tad_pkg::KIND_ENQ) begin
            if (fill == CNT_W'(QUEUE_DEPTH)) begin
              res_status_next = tad_pkg::ST_FULL;
            end else begin
              res_status_next = tad_pkg::ST_OK;
              ctl.load_enq    = 1'b1;
              fill_next       = fill + CNT_W'(1);
            end
          end else if (bad_w) begin
            res_status_next = tad_pkg::ST_BAD_WKR;
          end else begin
            res_status_next = tad_pkg::ST_NONE;
            ccmd.clear      = 1'b1;
            if (fill != '0) begin
              state_next   = S_SCAN;
              cnt_next     = fill;
              steps_next   = fill;
              granted_next = 1'b0;
            end
          end
        end
      end
      S_SCAN: begin
        ctl.shift     = 1'b1;
        ctl.keep_head = !grant_now;
        steps_next    = steps - CNT_W'(1);
        if (grant_now) begin
          granted_next    = 1'b1;
          cnt_next        = cnt - CNT_W'(1);
          res_status_next = tad_pkg::ST_OK;
          res_entry_next  = head;
          res_entry_next.more = 1'b0;
          ccmd.set        = head.reply && head.more;
        end
        if (steps == CNT_W'(1)) begin
          fill_next  = cnt_next;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt        <= cnt_next;
    steps      <= steps_next;
    granted    <= granted_next;
    take_w     <= take_w_next;
    res_status <= res_status_next;
    res_entry  <= res_entry_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_tuser <= res_status;
      m_tdata <= {res_entry.reply, res_entry.trans, res_entry.tag};
    end
  end

  // row of queue cells
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    tad_pkg::entry_t upper;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign upper = cells[i];
    end else begin : g_mid
      assign upper = cells[i+1];
    end
    tad_cell #(
      .IDX   (i),
      .CNT_W (CNT_W),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .fill        (fill),
      .tail        (tail),
      .enq_entry   (enq_entry),
      .head_entry  (head),
      .upper_entry (upper),
      .entry       (cells[i])
    );
  end

  tad_claims #(
    .WORKERS (WORKERS),
    .WID_W   (WID_W)
  ) u_claims (
    .clk         (clk),
    .rst         (rst),
    .cmd         (ccmd),
    .self_id     ((state == S_IDLE) ? WID_W'(in_worker) : take_w),
    .set_trans   (head.trans),
    .count       (eff),
    .query_trans (head.trans),
    .hit_other   (hit)
  );

  // checks
  `TAD_ASSERT(a_fill_bound, fill <= CNT_W'(QUEUE_DEPTH), "fill count beyond queue depth")
  `TAD_ASSERT(a_scan_cnt, (state != S_SCAN) || (cnt <= fill && steps != '0),
              "scan counters out of range")
  `TAD_ASSERT_NEXT(a_one_grant, state == S_SCAN && granted, granted,
                   "grant flag dropped inside a scan")
  `TAD_ASSERT(a_zero_fields, !m_tvalid || m_tuser == tad_pkg::ST_OK || m_tdata == '0,
              "nonzero result fields without a grant")

endmodule
